FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_CLK_NR(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/nst_pkg.sv
// Package for the neighbor site table: types, constants, codes.
package nst_pkg;
   localparam int DefTableDepth = 16;
   localparam logic [15:0] TtlReset = 16'd1800;

   typedef enum logic [2:0] {
      ACT_REJECT  = 3'd0,
      ACT_SITE    = 3'd1,
      ACT_FREQ    = 3'd2,
      ACT_APPEND  = 3'd3,
      ACT_REPLACE = 3'd4,
      ACT_TICK    = 3'd5
   } action_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_TICK   = 1'b1
   } opcode_type;

   typedef enum logic {
      CSR_CC_FREQ = 1'b0,
      CSR_TTL     = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] now_seconds;
      logic [31:0] freq_hz;
      logic [11:0] sys_id;
      logic [7:0]  rfss_id;
      logic [7:0]  site_id;
      logic [19:0] wacn_id;
      logic        wacn_present;
      logic [7:0]  area_code;
      logic        area_present;
      logic [3:0]  flag_bits;
      logic        flags_present;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [3:0] slot;
      logic [4:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [31:0] freq;
      logic [11:0] sys;
      logic [7:0]  rfss;
      logic [7:0]  site;
      logic [20:0] wacn;
      logic [8:0]  area;
      logic [4:0]  flags;
      logic [31:0] stamp;
   } entry_type;

   localparam int EntryWidth = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SITE,
      ST_FREQ,
      ST_OLD,
      ST_WRITE,
      ST_TICK,
      ST_CLEAR,
      ST_DONE
   } state_type;

   function automatic logic same_site(entry_type e, req_type r);
      logic partial;
      partial = (e.rfss == 8'd0) || (e.site == 8'd0) || (r.rfss_id == 8'd0) ||
                (r.site_id == 8'd0);
      if (partial)
         return (e.sys == r.sys_id) && (e.rfss == r.rfss_id) && (e.site == r.site_id);
      return (e.rfss == r.rfss_id) && (e.site == r.site_id) &&
             ((e.sys == r.sys_id) || (e.sys == 12'd0) || (r.sys_id == 12'd0));
   endfunction

   function automatic entry_type merge(entry_type e, req_type r, logic copy_id);
      entry_type m;
      m = e;
      m.freq = r.freq_hz;
      if (copy_id) begin
         m.sys  = r.sys_id;
         m.rfss = r.rfss_id;
         m.site = r.site_id;
      end
      if (r.wacn_present) m.wacn = {1'b1, r.wacn_id};
      if (r.area_present) m.area = {1'b1, r.area_code};
      if (r.flags_present) m.flags = {1'b1, r.flag_bits};
      m.stamp = r.now_seconds;
      return m;
   endfunction
endpackage

FILE: rtl/core/neighbor_site_table.sv
// Neighbor site table: top level with walk sequencer over the entry RAM.
// An update runs a site walk, a frequency walk and an oldest search as needed;
// a tick runs a compaction walk plus clearing of vacated rows.
// One item at a time; each walk reads one RAM row a cycle.
// Result is held in an output register; next request is accepted meanwhile.
// Synchronous active-high reset clears control and the occupancy count;
// rows past the count are never read, so the RAM needs no clearing pass.
module neighbor_site_table
   import nst_pkg::*;
#(
   parameter int TABLE_DEPTH = DefTableDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
`include "assert_macros.svh"
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [31:0] cc_freq;
   logic [15:0] ttl;

   nst_csr u_csr (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_wdata,
      .cc_freq, .ttl
   );

   state_type   state_ff, state_in;
   req_type     req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;     // read index of row presented next cycle
   logic [CW-1:0] wpos_ff, wpos_in;   // compaction write pointer
   logic        rd_pend_ff, rd_pend_in; // RAM output holds row idx_ff-1
   logic [AW-1:0] best_ff, best_in;
   logic [31:0] best_ts_ff, best_ts_in;
   logic [AW-1:0] tgt_ff, tgt_in;
   entry_type   base_ff, base_in;
   logic        copy_ff, copy_in;
   logic        fixsys_ff, fixsys_in;
   action_type  act_ff, act_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type   wr_data, rd_data;

   nst_ram #(.Width(EntryWidth), .Depth(TABLE_DEPTH)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   logic has_id, rejected, accept, last_row;
   logic [AW-1:0] cur;
   logic signed [32:0] age;
   logic keep;
   entry_type merged;

   assign has_id   = (req_ff.sys_id != 12'd0) || (req_ff.rfss_id != 8'd0) ||
                     (req_ff.site_id != 8'd0);
   assign rejected = (req_ff.freq_hz == 32'd0) || (req_ff.freq_hz == cc_freq);
   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign cur      = AW'(idx_ff - CW'(1));
   assign last_row = (idx_ff == count_ff);
   assign age      = $signed({1'b0, req_ff.now_seconds}) - $signed({1'b0, rd_data.stamp});
   assign keep     = (rd_data.freq != 32'd0) &&
                     ((rd_data.stamp == 32'd0) || (age <= $signed({17'd0, ttl})));
   assign rd_addr  = AW'(idx_ff);

   always_comb begin
      merged = merge(base_ff, req_ff, copy_ff);
      if (fixsys_ff && (base_ff.sys == 12'd0)) merged.sys = req_ff.sys_id;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = (req_data.opcode == OP_TICK) ? ST_TICK : ST_SITE;
         ST_SITE: begin
            if (rejected) state_in = ST_DONE;
            else if (!has_id || count_ff == '0) state_in = ST_FREQ;
            else if (rd_pend_ff) begin
               if (same_site(rd_data, req_ff) &&
                   !(req_ff.wacn_present && rd_data.wacn[20] &&
                     rd_data.wacn[19:0] != req_ff.wacn_id)) state_in = ST_WRITE;
               else if (last_row) state_in = ST_FREQ;
            end
         end
         ST_FREQ: begin
            if (count_ff == '0) state_in = ST_WRITE;
            else if (rd_pend_ff) begin
               if (rd_data.freq == req_ff.freq_hz &&
                   !(has_id && (rd_data.sys != '0 || rd_data.rfss != '0 ||
                                rd_data.site != '0))) state_in = ST_WRITE;
               else if (last_row)
                  state_in = (count_ff < CW'(TABLE_DEPTH)) ? ST_WRITE : ST_OLD;
            end
         end
         ST_OLD: if (rd_pend_ff && last_row) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_TICK: if (count_ff == '0 || (rd_pend_ff && last_row)) state_in = ST_CLEAR;
         ST_CLEAR: if (idx_ff >= count_ff) state_in = ST_DONE;
         ST_DONE: if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      req_in      = req_ff;
      count_in    = count_ff;
      idx_in      = idx_ff;
      wpos_in     = wpos_ff;
      rd_pend_in  = 1'b0;
      best_in     = best_ff;
      best_ts_in  = best_ts_ff;
      tgt_in      = tgt_ff;
      base_in     = base_ff;
      copy_in     = copy_ff;
      fixsys_in   = fixsys_ff;
      act_in      = act_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in      = rsp_ff;
      wr_en       = 1'b0;
      wr_addr     = tgt_ff;
      wr_data     = merged;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in = req_data;
               idx_in = '0;
               wpos_in = '0;
               act_in = ACT_REJECT;
               tgt_in = '0;
            end
         end
         ST_SITE: begin
            if (state_in == ST_SITE) begin
               idx_in = idx_ff + CW'(1);
               rd_pend_in = 1'b1;
            end else if (state_in == ST_WRITE) begin
               tgt_in = cur; base_in = rd_data; copy_in = 1'b0; fixsys_in = 1'b1;
               act_in = ACT_SITE;
            end else if (state_in == ST_FREQ) begin
               idx_in = '0;
            end
         end
         ST_FREQ: begin
            if (state_in == ST_FREQ) begin
               idx_in = idx_ff + CW'(1);
               rd_pend_in = 1'b1;
            end else if (state_in == ST_OLD) begin
               idx_in = '0;
               best_in = '0;
               best_ts_in = '1;
            end else if (rd_pend_ff && rd_data.freq == req_ff.freq_hz &&
                         !(has_id && (rd_data.sys != '0 || rd_data.rfss != '0 ||
                                      rd_data.site != '0))) begin
               tgt_in = cur; base_in = rd_data; copy_in = has_id; fixsys_in = 1'b0;
               act_in = ACT_FREQ;
            end else begin
               tgt_in = AW'(count_ff); base_in = '0; copy_in = 1'b1; fixsys_in = 1'b0;
               act_in = ACT_APPEND;
               count_in = count_ff + CW'(1);
            end
         end
         ST_OLD: begin
            if (!last_row || !rd_pend_ff) begin
               idx_in = idx_ff + CW'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff) begin
               if (cur == '0 || rd_data.stamp < best_ts_ff) begin
                  best_in = cur; best_ts_in = rd_data.stamp;
               end
               if (last_row) begin
                  tgt_in = (cur == '0 || rd_data.stamp < best_ts_ff) ? cur : best_ff;
                  base_in = '0; copy_in = 1'b1; fixsys_in = 1'b0;
                  act_in = ACT_REPLACE;
               end
            end
         end
         ST_WRITE: begin
            wr_en = 1'b1;
         end
         ST_TICK: begin
            if (state_in == ST_TICK) begin
               idx_in = idx_ff + CW'(1);
               rd_pend_in = 1'b1;
            end
            if (rd_pend_ff && keep) begin
               wr_en = 1'b1;
               wr_addr = AW'(wpos_ff);
               wr_data = rd_data;
               wpos_in = wpos_ff + CW'(1);
            end
            if (state_in == ST_CLEAR) idx_in = (rd_pend_ff && keep) ? wpos_ff + CW'(1) : wpos_ff;
         end
         ST_CLEAR: begin
            if (idx_ff < count_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff);
               wr_data = '0;
               idx_in = idx_ff + CW'(1);
            end else begin
               count_in = wpos_ff;
               act_in = ACT_TICK;
            end
         end
         ST_DONE: begin
            if (state_in == ST_IDLE) begin
               rsp_valid_in = 1'b1;
               rsp_in = '{action: act_ff, slot: 4'(tgt_ff), occupancy: 5'(count_ff)};
            end
         end
         default: rsp_in = rsp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         rd_pend_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      idx_ff     <= idx_in;
      wpos_ff    <= wpos_in;
      best_ff    <= best_in;
      best_ts_ff <= best_ts_in;
      tgt_ff     <= tgt_in;
      base_ff    <= base_in;
      copy_ff    <= copy_in;
      fixsys_ff  <= fixsys_in;
      act_ff     <= act_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_CLK(a_count_range, clock, reset, count_ff <= CW'(TABLE_DEPTH), "count over depth")
   `ASSERT_CLK(a_no_accept_busy, clock, reset, (state_ff != ST_IDLE) |-> !accept,
               "accepted while busy")
   `ASSERT_CLK(a_rsp_after_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE),
               "response outside done")
   `ASSERT_CLK(a_wr_in_range, clock, reset, wr_en |-> (CW'(wr_addr) < CW'(TABLE_DEPTH)),
               "write beyond table")
endmodule

FILE: rtl/core/nst_ram.sv
// Generic single-port-write, registered-read RAM.
module nst_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: rtl/core/nst_csr.sv
// Configuration registers of the neighbor site table.
module nst_csr
   import nst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output logic [31:0] cc_freq,
   output logic [15:0] ttl
);
   logic [31:0] cc_freq_ff, cc_freq_in;
   logic [15:0] ttl_ff, ttl_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cc_freq_in = cc_freq_ff;
      ttl_in     = ttl_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_CC_FREQ: cc_freq_in = csr_wdata;
            CSR_TTL:     ttl_in = csr_wdata[15:0];
            default:     cc_freq_in = cc_freq_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cc_freq_ff <= '0;
         ttl_ff     <= TtlReset;
      end else begin
         cc_freq_ff <= cc_freq_in;
         ttl_ff     <= ttl_in;
      end
   end

   assign cc_freq = cc_freq_ff;
   assign ttl     = ttl_ff;
endmodule
